// File: hdl/pps_pkg.sv
package pps_pkg;

    localparam int CLOCK_W = 20;
    localparam int WORK_W  = 24;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;

    // Operation codes carried in the func field of an input item.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic        func;
        logic [7:0]  proc_id;
        logic [7:0]  prio_level;
        logic [15:0] arrive_at;
        logic [15:0] burst_len;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic               ran;
        logic [7:0]         run_id;
        logic [CLOCK_W-1:0] time_now;
        logic               finished;
        logic [CLOCK_W-1:0] turnaround;
        logic [CLOCK_W-1:0] waiting;
        logic [CLOCK_W-1:0] response;
        logic               all_done;
    } t_res;

    // One entry of the process table.
    typedef struct packed {
        logic [7:0]         id;
        logic [7:0]         prio;
        logic [15:0]        arrival;
        logic [15:0]        burst;
        logic [15:0]        remaining;
        logic [CLOCK_W-1:0] start;
        logic               started;
        logic               done;
    } t_slot;

endpackage

// File: hdl/pps_pick.sv
module pps_pick #(
    parameter int AW = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_cand_valid,
    input  pps_pkg::t_slot               i_cand,
    input  logic [AW-1:0]                i_cand_idx,
    input  logic [pps_pkg::CLOCK_W-1:0]  i_clock,
    output logic                         o_found,
    output logic [AW-1:0]                o_best_idx
);

    logic          r_found;
    logic [AW-1:0] r_idx;
    logic [7:0]    r_prio;
    logic [7:0]    r_id;
    logic          w_ready;
    logic          w_better;
    logic          w_take;

    // A candidate is eligible when it is unfinished and has arrived.
    assign w_ready  = !i_cand.done &&
                      ({{(pps_pkg::CLOCK_W-16){1'b0}}, i_cand.arrival} <= i_clock);
    // Strictly better only, so equal keys keep the earlier slot.
    assign w_better = (i_cand.prio < r_prio) ||
                      ((i_cand.prio == r_prio) && (i_cand.id < r_id));
    assign w_take   = i_cand_valid && w_ready && (!r_found || w_better);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx  <= i_cand_idx;
            r_prio <= i_cand.prio;
            r_id   <= i_cand.id;
        end
    end

    assign o_found    = r_found;
    assign o_best_idx = r_idx;

endmodule

// File: hdl/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler.
// An item is given on i_cmd and taken at a rising edge where start is high
// and busy is low. A load item (func = load) appends a process to the table
// unless it is full or the burst is zero; a tick item (func = tick) advances
// time by one unit and runs the ready, unfinished process with the smallest
// priority number (ties go to the smaller id, then to the earlier slot).
// Every item yields exactly one result on o_res, shown for a single cycle
// with o_valid high. The receiver cannot hold results off, so it must take
// each result in the cycle o_valid is high.
// A load item or a tick on an empty table returns its result in the cycle
// after acceptance. Any other tick scans the table one slot per cycle
// through the shared comparator and a single table read port; the result
// follows the scan when no process is ready, follows an update step that
// rewrites the winning slot when one runs, and follows a further finish
// step when the process completes and the waiting time still has to be
// worked out. The next item may be given in the cycle the result is shown.
// A synchronous active-low reset empties the table, zeroes the clock and
// the outstanding work count, and leaves the block ready at once; the table
// contents themselves are not cleared since only filled slots are read.
module preemptive_priority_scheduler_top #(
    parameter int MAX_PROCS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  pps_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_valid,
    output pps_pkg::t_res o_res
);

    localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int CKW = pps_pkg::CLOCK_W;
    localparam int WKW = pps_pkg::WORK_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PROCS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;

    // Process table: one write port and one registered read port.
    pps_pkg::t_slot r_mem [MAX_PROCS];
    pps_pkg::t_slot r_rdata;

    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CKW-1:0] r_clock, n_clock;
    logic [WKW-1:0] r_work,  n_work;
    logic [CW-1:0]  r_idx,   n_idx;
    logic           r_pend,  n_pend;
    logic [AW-1:0]  r_pend_idx, n_pend_idx;
    logic           r_valid, n_valid;
    pps_pkg::t_res  r_res,   n_res;

    // Operands held between the update and finish steps.
    logic [CKW-1:0] r_tat,   n_tat;
    logic [CKW-1:0] r_resp,  n_resp;
    logic [15:0]    r_burst, n_burst;
    logic [7:0]     r_id,    n_id;

    logic           w_accept;
    logic [AW-1:0]  w_rd_addr;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    pps_pkg::t_slot w_wr_data;
    logic           w_clear;
    logic           w_found;
    logic [AW-1:0]  w_best_idx;
    logic [CKW-1:0] w_clock_inc;
    logic [WKW-1:0] w_work_dec;
    logic [CKW-1:0] w_start;
    logic [CKW-1:0] w_wait_diff;

    assign w_accept    = start && !busy;
    assign w_clock_inc = (r_clock == pps_pkg::CLOCK_MAX) ? r_clock : r_clock + 1'b1;
    assign w_work_dec  = (r_work != '0) ? r_work - 1'b1 : r_work;
    assign w_start     = r_rdata.started ? r_rdata.start : r_clock;
    assign w_wait_diff = r_tat - {{(CKW-16){1'b0}}, r_burst};

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_rd_addr];
    end

    pps_pick #(
        .AW (AW)
    ) u_pick (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_clear),
        .i_cand_valid (r_pend),
        .i_cand       (r_rdata),
        .i_cand_idx   (r_pend_idx),
        .i_clock      (r_clock),
        .o_found      (w_found),
        .o_best_idx   (w_best_idx)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_clock    = r_clock;
        n_work     = r_work;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_valid    = 1'b0;
        n_res      = r_res;
        n_tat      = r_tat;
        n_resp     = r_resp;
        n_burst    = r_burst;
        n_id       = r_id;
        w_rd_addr  = r_idx[AW-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = r_count[AW-1:0];
        w_wr_data  = r_rdata;
        w_clear    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_valid        = 1'b1;
                    n_res          = '0;
                    n_res.status   = pps_pkg::ST_OK;
                    n_res.time_now = r_clock;
                    if (i_cmd.func == pps_pkg::FUNC_LOAD) begin
                        if (r_count >= COUNT_MAX) begin
                            n_res.status = pps_pkg::ST_FULL;
                        end else if (i_cmd.burst_len == '0) begin
                            n_res.status = pps_pkg::ST_ZERO;
                        end else begin
                            w_wr_en             = 1'b1;
                            w_wr_data.id        = i_cmd.proc_id;
                            w_wr_data.prio      = i_cmd.prio_level;
                            w_wr_data.arrival   = i_cmd.arrive_at;
                            w_wr_data.burst     = i_cmd.burst_len;
                            w_wr_data.remaining = i_cmd.burst_len;
                            w_wr_data.start     = '0;
                            w_wr_data.started   = 1'b0;
                            w_wr_data.done      = 1'b0;
                            n_count             = r_count + 1'b1;
                            n_work = r_work + {{(WKW-16){1'b0}}, i_cmd.burst_len};
                        end
                        n_res.all_done = (n_work == '0);
                    end else if (r_count == '0) begin
                        // Nothing loaded: an idle tick needs no scan.
                        n_clock        = w_clock_inc;
                        n_res.time_now = w_clock_inc;
                        n_res.all_done = (r_work == '0);
                    end else begin
                        n_valid = 1'b0;
                        n_idx   = '0;
                        w_clear = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Issue one table read per cycle; the comparator sees the
                // data of the previous read while the next one is in flight.
                if (r_idx < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[AW-1:0];
                    n_idx      = r_idx + 1'b1;
                end else if (!r_pend) begin
                    if (w_found) begin
                        w_rd_addr = w_best_idx;
                        n_state   = S_UPDATE;
                    end else begin
                        n_clock        = w_clock_inc;
                        n_valid        = 1'b1;
                        n_res          = '0;
                        n_res.time_now = w_clock_inc;
                        n_res.all_done = (r_work == '0);
                        n_state        = S_IDLE;
                    end
                end
            end

            S_UPDATE: begin
                // Read-modify-write of the winning slot.
                w_wr_en             = 1'b1;
                w_wr_addr           = w_best_idx;
                w_wr_data           = r_rdata;
                w_wr_data.remaining = r_rdata.remaining - 1'b1;
                w_wr_data.started   = 1'b1;
                w_wr_data.start     = w_start;
                w_wr_data.done      = (r_rdata.remaining == 16'd1);
                n_clock             = w_clock_inc;
                n_work              = w_work_dec;
                n_tat   = w_clock_inc - {{(CKW-16){1'b0}}, r_rdata.arrival};
                n_resp  = w_start - {{(CKW-16){1'b0}}, r_rdata.arrival};
                n_burst = r_rdata.burst;
                n_id    = r_rdata.id;
                if (r_rdata.remaining == 16'd1) begin
                    n_state = S_FINISH;
                end else begin
                    n_valid        = 1'b1;
                    n_res          = '0;
                    n_res.ran      = 1'b1;
                    n_res.run_id   = r_rdata.id;
                    n_res.time_now = w_clock_inc;
                    n_res.all_done = (w_work_dec == '0);
                    n_state        = S_IDLE;
                end
            end

            S_FINISH: begin
                // A saturated clock can leave turnaround below the burst.
                n_valid          = 1'b1;
                n_res            = '0;
                n_res.ran        = 1'b1;
                n_res.run_id     = r_id;
                n_res.time_now   = r_clock;
                n_res.finished   = 1'b1;
                n_res.turnaround = r_tat;
                n_res.waiting    = (r_tat >= {{(CKW-16){1'b0}}, r_burst}) ?
                                   w_wait_diff : '0;
                n_res.response   = r_resp;
                n_res.all_done   = (r_work == '0);
                n_state          = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_clock <= '0;
            r_work  <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clock <= n_clock;
            r_work  <= n_work;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
        r_tat      <= n_tat;
        r_resp     <= n_resp;
        r_burst    <= n_burst;
        r_id       <= n_id;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: sim/tb_preemptive_priority_scheduler_top.sv
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler_top;

    // The table size the block is built with. Slots are never freed, so
    // one run can load at most this many processes.
    localparam int SLOTS = 16;

    // Widths of the time values and of the outstanding work count.
    localparam int CKW = pps_pkg::CLOCK_W;
    localparam int WKW = pps_pkg::WORK_W;

    // Length of the random part, in items.
    localparam int RANDOM_ITEMS = 450;

    // The slowest item and the longest gap the sender draws are both far
    // shorter than this, so no handshake can be quiet for anything like this long.
    localparam int STALL_LIMIT = 2000;

    // Cycles to keep watching after the last expected result, so that a
    // stray extra result still gets caught.
    localparam int TAIL_CYCLES = 40;

    // Detailed mismatch lines are capped to keep the log readable.
    localparam int MAX_MISMATCH_LINES = 100;

    logic          clk     = 1'b0;
    logic          rst_n   = 1'b0;
    logic          start   = 1'b0;
    pps_pkg::t_cmd cmd_bus = '0;
    logic          busy;
    logic          res_valid;
    pps_pkg::t_res res_bus;

    always #1 clk = ~clk;

    preemptive_priority_scheduler_top #(
        .MAX_PROCS(SLOTS)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .start  (start),
        .i_cmd  (cmd_bus),
        .busy   (busy),
        .o_valid(res_valid),
        .o_res  (res_bus)
    );

    // ------------------------------------------------------------------
    // Scheduler predictor state. Only slots below procs_loaded are read.
    // ------------------------------------------------------------------
    logic [7:0]     proc_id_tbl    [SLOTS];
    logic [7:0]     proc_prio_tbl  [SLOTS];
    logic [15:0]    proc_arr_tbl   [SLOTS];
    logic [15:0]    proc_burst_tbl [SLOTS];
    logic [15:0]    proc_left_tbl  [SLOTS];
    logic [CKW-1:0] proc_first_tbl [SLOTS];
    bit             proc_began     [SLOTS];
    bit             proc_over      [SLOTS];
    int             procs_loaded = 0;
    logic [CKW-1:0] sched_clock  = '0;
    logic [WKW-1:0] work_owed    = '0;

    // Items waiting to be sent, and the reports the block still owes us.
    pps_pkg::t_cmd cmd_backlog[$];
    pps_pkg::t_res predicted_reports[$];

    // Handshake bookkeeping: the driver counts items it has put on the
    // bus, the monitor counts items the block has taken.
    int n_issued  = 0;
    int n_taken   = 0;
    int hold_off  = 0;
    int calm_left = 0;
    int errors    = 0;

    // Stimulus generator bookkeeping: the time the block will have reached
    // and how many loads it will have kept.
    int stim_clock  = 0;
    int stim_loaded = 0;

    // Tallies for the closing summary.
    int n_loads   = 0;
    int n_rejects = 0;
    int n_ticks   = 0;
    int n_idle    = 0;
    int n_done    = 0;

    // Works out the report for one accepted item and updates the table.
    // A load appends a process unless the table is full (checked first) or
    // the burst is zero. A tick runs the ready, unfinished process with the
    // smallest priority number; ties go to the smaller id and then to the
    // earlier slot, which is why a later slot must be strictly better.
    function automatic pps_pkg::t_res predict_report(input pps_pkg::t_cmd c);
        pps_pkg::t_res  r;
        int             best;
        bit             found;
        logic [CKW-1:0] tat;
        r     = '0;
        best  = 0;
        found = 1'b0;
        if (c.func == pps_pkg::FUNC_LOAD) begin
            if (procs_loaded >= SLOTS) begin
                r.status = pps_pkg::ST_FULL;
            end else if (c.burst_len == 16'd0) begin
                r.status = pps_pkg::ST_ZERO;
            end else begin
                proc_id_tbl[procs_loaded]    = c.proc_id;
                proc_prio_tbl[procs_loaded]  = c.prio_level;
                proc_arr_tbl[procs_loaded]   = c.arrive_at;
                proc_burst_tbl[procs_loaded] = c.burst_len;
                proc_left_tbl[procs_loaded]  = c.burst_len;
                proc_first_tbl[procs_loaded] = '0;
                proc_began[procs_loaded]     = 1'b0;
                proc_over[procs_loaded]      = 1'b0;
                procs_loaded++;
                work_owed = work_owed + WKW'(c.burst_len);
            end
        end else begin
            for (int i = 0; i < procs_loaded; i++) begin
                if (!proc_over[i] && CKW'(proc_arr_tbl[i]) <= sched_clock) begin
                    if (!found || proc_prio_tbl[i] < proc_prio_tbl[best] ||
                        (proc_prio_tbl[i] == proc_prio_tbl[best] &&
                         proc_id_tbl[i] < proc_id_tbl[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found) begin
                r.ran    = 1'b1;
                r.run_id = proc_id_tbl[best];
                if (!proc_began[best]) begin
                    proc_began[best]     = 1'b1;
                    proc_first_tbl[best] = sched_clock;
                end
                proc_left_tbl[best] = proc_left_tbl[best] - 1'b1;
                if (work_owed != '0) begin
                    work_owed = work_owed - 1'b1;
                end
                if (sched_clock != pps_pkg::CLOCK_MAX) begin
                    sched_clock = sched_clock + 1'b1;
                end
                if (proc_left_tbl[best] == 16'd0) begin
                    proc_over[best] = 1'b1;
                    tat             = sched_clock - CKW'(proc_arr_tbl[best]);
                    r.finished      = 1'b1;
                    r.turnaround    = tat;
                    r.waiting       = (tat >= CKW'(proc_burst_tbl[best])) ?
                                      tat - CKW'(proc_burst_tbl[best]) : '0;
                    r.response      = proc_first_tbl[best] - CKW'(proc_arr_tbl[best]);
                end
            end else if (sched_clock != pps_pkg::CLOCK_MAX) begin
                sched_clock = sched_clock + 1'b1;
            end
        end
        r.time_now = sched_clock;
        r.all_done = (work_owed == '0);
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_MISMATCH_LINES) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            end
        end
    endfunction

    function automatic void compare_report(input pps_pkg::t_res want,
                                           input pps_pkg::t_res got);
        check_field("status",     32'(want.status),     32'(got.status));
        check_field("ran",        32'(want.ran),        32'(got.ran));
        check_field("run_id",     32'(want.run_id),     32'(got.run_id));
        check_field("time_now",   32'(want.time_now),   32'(got.time_now));
        check_field("finished",   32'(want.finished),   32'(got.finished));
        check_field("turnaround", 32'(want.turnaround), 32'(got.turnaround));
        check_field("waiting",    32'(want.waiting),    32'(got.waiting));
        check_field("response",   32'(want.response),   32'(got.response));
        check_field("all_done",   32'(want.all_done),   32'(got.all_done));
    endfunction

    // Stimulus helpers. A load that the block will keep bumps the slot
    // count; a tick advances the time the generator expects the block to
    // be at, so that random arrivals land near the present.
    function automatic void add_load(input logic [7:0] id, input logic [7:0] prio,
                                     input logic [15:0] arr, input logic [15:0] burst);
        pps_pkg::t_cmd c;
        c.func       = pps_pkg::FUNC_LOAD;
        c.proc_id    = id;
        c.prio_level = prio;
        c.arrive_at  = arr;
        c.burst_len  = burst;
        cmd_backlog.push_back(c);
        if (burst != 16'd0 && stim_loaded < SLOTS) begin
            stim_loaded++;
        end
    endfunction

    // The unused fields of a tick carry random values; the block must
    // ignore them.
    function automatic void add_tick();
        pps_pkg::t_cmd c;
        c.func       = pps_pkg::FUNC_TICK;
        c.proc_id    = 8'($urandom);
        c.prio_level = 8'($urandom);
        c.arrive_at  = 16'($urandom);
        c.burst_len  = 16'($urandom);
        cmd_backlog.push_back(c);
        stim_clock++;
    endfunction

    // Cycles to leave the bus idle before the next item. Now and then a
    // calm stretch of back-to-back items is inserted.
    function automatic int draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = int'($urandom_range(10, 30));
            return 0;
        end
        return int'($urandom_range(0, 12));
    endfunction

    // ------------------------------------------------------------------
    // Driver. It works on the falling edge. When the item on the bus was
    // taken at the last rising edge (or the bus is idle) it either waits
    // out the drawn gap or puts the next item up. Start is written once per
    // edge, so an item that follows with no gap keeps start high.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || n_taken == n_issued) begin
            if (start) begin
                hold_off = draw_gap();
            end
            if (hold_off != 0 || cmd_backlog.size() == 0) begin
                if (hold_off != 0) begin
                    hold_off--;
                end
                start <= 1'b0;
            end else begin
                cmd_bus <= cmd_backlog.pop_front();
                start   <= 1'b1;
                n_issued++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. On each rising edge it first checks a result that is shown,
    // then predicts the report for an item that is taken. A result can
    // never belong to an item taken at the same edge, so this order keeps
    // a stray result from being matched to a fresh expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        pps_pkg::t_res want;
        if (rst_n) begin
            if (res_valid) begin
                if (predicted_reports.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, expected nothing, got %h",
                             $time, res_bus);
                end else begin
                    want = predicted_reports.pop_front();
                    compare_report(want, res_bus);
                end
            end
            if (start && !busy) begin
                want = predict_report(cmd_bus);
                predicted_reports.push_back(want);
                n_taken++;
                if (cmd_bus.func == pps_pkg::FUNC_LOAD) begin
                    n_loads++;
                    if (want.status != pps_pkg::ST_OK) begin
                        n_rejects++;
                    end
                end else begin
                    n_ticks++;
                    if (!want.ran) begin
                        n_idle++;
                    end
                    if (want.finished) begin
                        n_done++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run once a quiet spell, with no item taken and no
    // result shown, reaches STALL_LIMIT.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || res_valid) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [15:0] arr;
        int          total_items;

        // Directed part. An idle tick on the empty table, then two loads
        // with a zero burst carrying the field extremes. Then six processes:
        // one with the smallest burst, one with the lowest priority that
        // only runs once everything else is done, one with the highest
        // priority that arrives later and preempts, a priority tie broken
        // by the smaller id, and an exact id and priority tie broken by the
        // earlier slot. Twelve ticks run all of them to completion, the
        // last tick finding nothing ready so that all_done comes back.
        add_tick();
        add_load(8'd255, 8'd255, 16'hFFFF, 16'd0);
        add_load(8'd0,   8'd0,   16'd0,    16'd0);
        add_load(8'd7,   8'd3,   16'd0,    16'd1);
        add_load(8'd255, 8'd255, 16'd0,    16'd3);
        add_load(8'd0,   8'd0,   16'd4,    16'd2);
        add_load(8'd9,   8'd3,   16'd1,    16'd2);
        add_load(8'd5,   8'd3,   16'd1,    16'd2);
        add_load(8'd5,   8'd3,   16'd1,    16'd1);
        repeat (12) add_tick();

        // Random part. While slots remain, well-formed loads arrive near
        // the present with small ids and priorities so that ties and
        // preemptions are common; a few carry a zero burst. Once the table
        // is full, an occasional load with fully random fields must be
        // turned away as full, even when its burst is zero. Everything
        // else is a tick.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (stim_loaded < SLOTS && $urandom_range(0, 5) == 0) begin
                if (stim_clock > 10 && $urandom_range(0, 2) == 0) begin
                    arr = 16'(stim_clock - int'($urandom_range(0, 10)));
                end else begin
                    arr = 16'(stim_clock + int'($urandom_range(0, 30)));
                end
                add_load(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)), arr,
                         ($urandom_range(0, 7) == 0) ? 16'd0 :
                         16'($urandom_range(1, 48)));
            end else if (stim_loaded == SLOTS && $urandom_range(0, 11) == 0) begin
                add_load(8'($urandom), 8'($urandom), 16'($urandom),
                         ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
            end else begin
                add_tick();
            end
        end
        total_items = cmd_backlog.size();

        // Reset is held low from the start and released on a falling edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every item is taken and every report has arrived,
        // then watch a while longer for anything extra.
        while (n_taken < total_items) @(posedge clk);
        while (predicted_reports.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d items: %0d loads (%0d turned away) and %0d ticks.",
                 n_taken, n_loads, n_rejects, n_ticks);
        $display("Ticks saw %0d completions and %0d with no ready process; %0d mismatches.",
                 n_done, n_idle, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
